// ===== rtl/core/lrb_pkg.sv =====
// lrb_pkg: widths, reset values and the CORDIC arctangent table shared by
// the landmark range/bearing block. No dependencies.
`default_nettype none

package lrb_pkg;

    localparam int POS_W    = 32;   // Q16.16 positions
    localparam int ANG_W    = 16;   // binary angle, 32768 = pi
    localparam int DIST_W   = 33;   // Q17.16 distance
    localparam int NUM_W    = 16;   // landmark number
    localparam int DIFF_W   = POS_W + 1;
    localparam int CORDIC_W = 36;   // holds 1.647 * sqrt(2) * 2^32 with sign
    localparam int Z_W      = 32;   // angle accumulator, 2^32 per turn
    localparam int IDX_W    = 5;    // step index into the atan table
    localparam int ATAN_N   = 32;

    localparam int CORDIC_STEPS_DEF = 16;

    localparam logic [POS_W-1:0] MAX_RANGE_RST = 32'd655360;   // 10.0 m
    localparam logic [Z_W-1:0]   Z_HALF_TURN   = 32'h8000_0000;

    // atan(2^-i), 2^32 units per turn
    localparam logic [Z_W-1:0] ATAN_TAB [ATAN_N] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

endpackage

`default_nettype wire

// ===== rtl/core/lrb_in_if.sv =====
// lrb_in_if: input channel of the range/bearing block, one landmark per beat.
// Depends on lrb_pkg.
`default_nettype none

interface lrb_in_if import lrb_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    start_of_frame;
    logic signed [POS_W-1:0] robot_x;
    logic signed [POS_W-1:0] robot_y;
    logic signed [ANG_W-1:0] robot_heading;
    logic signed [POS_W-1:0] landmark_x;
    logic signed [POS_W-1:0] landmark_y;

    modport source (
        output valid, start_of_frame, robot_x, robot_y, robot_heading,
               landmark_x, landmark_y,
        input  ready
    );
    modport sink (
        input  valid, start_of_frame, robot_x, robot_y, robot_heading,
               landmark_x, landmark_y,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/core/lrb_out_if.sv =====
// lrb_out_if: result channel of the range/bearing block, one result per beat.
// Depends on lrb_pkg.
`default_nettype none

interface lrb_out_if import lrb_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [DIST_W-1:0]       distance;
    logic signed [ANG_W-1:0] relative_angle;
    logic                    visible;
    logic [NUM_W-1:0]        landmark_number;

    modport source (
        output valid, distance, relative_angle, visible, landmark_number,
        input  ready
    );
    modport sink (
        input  valid, distance, relative_angle, visible, landmark_number,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/core/landmark_range_bearing.sv =====
// landmark_range_bearing: top level. Range and bearing from robot to landmark.
// Depends on lrb_pkg, lrb_in_if, lrb_out_if, lrb_isqrt, lrb_cordic.
//
// Usage:
//   i_in carries one landmark per beat with the robot pose; o_out returns one
//   result beat per landmark: distance (Q17.16), bearing relative to heading
//   (binary angle), visible (distance < max_range) and the landmark number.
//   i_cfg_wr_en/i_cfg_wr_data write max_range; write it only while idle.
//   One item at a time: i_in.ready is high only while the block is idle.
//   An accepted item passes through a load state and then the computation, and the
//   next item can be accepted in the cycle the result appears. The square root (33
//   single-bit steps after two multiplies and a sum on one multiplier) is the
//   slower unit; the CORDIC runs alongside it.
//   The result sits in an output register, so a new item is accepted while it
//   waits; if the receiver still stalls when the next result is done, that
//   result holds inside and i_in.ready stays low.
//   Synchronous reset clears the counter, loads max_range = 10.0 m and drops
//   o_out.valid.
`default_nettype none

module landmark_range_bearing import lrb_pkg::*; #(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_wr_en,
    input  wire logic [POS_W-1:0] i_cfg_wr_data,
    lrb_in_if.sink                i_in,
    lrb_out_if.source             o_out
);

    typedef enum logic [2:0] {
        T_IDLE = 3'b001,
        T_LOAD = 3'b010,
        T_RUN  = 3'b100
    } t_top_state;

    t_top_state               r_state, n_state;
    logic [POS_W-1:0]         r_max_range;
    logic [NUM_W-1:0]         r_cnt, r_num;
    logic signed [DIFF_W-1:0] r_dx, r_dy;
    logic [ANG_W-1:0]         r_head;
    logic                     r_out_valid;
    logic [DIST_W-1:0]        r_dist;
    logic [ANG_W-1:0]         r_rel;
    logic                     r_vis;
    logic [NUM_W-1:0]         r_out_num;

    logic                     accept, out_free, finish;
    logic [NUM_W-1:0]         num_now;
    logic                     sq_done, cd_done;
    logic [DIST_W-1:0]        root;
    logic [Z_W-1:0]           z;
    logic [ANG_W-1:0]         ang;

    assign accept   = i_in.valid && (r_state == T_IDLE);
    assign out_free = !r_out_valid || o_out.ready;
    assign finish   = (r_state == T_RUN) && sq_done && cd_done && out_free;
    assign num_now  = i_in.start_of_frame ? '0 : r_cnt;
    // round half up from 2^32 to 2^16 units per turn
    assign ang      = z[Z_W-1 -: ANG_W] + ANG_W'(z[Z_W-ANG_W-1]);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            T_IDLE:  if (accept) n_state = T_LOAD;
            T_LOAD:  n_state = T_RUN;
            T_RUN:   if (finish) n_state = T_IDLE;
            default: n_state = T_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= T_IDLE;
            r_max_range <= MAX_RANGE_RST;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_max_range <= i_cfg_wr_data;
            end
            if (accept) begin
                r_cnt <= (num_now == '1) ? num_now : num_now + 1'b1;
            end
            if (finish) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_dx   <= {i_in.landmark_x[POS_W-1], i_in.landmark_x}
                    - {i_in.robot_x[POS_W-1], i_in.robot_x};
            r_dy   <= {i_in.landmark_y[POS_W-1], i_in.landmark_y}
                    - {i_in.robot_y[POS_W-1], i_in.robot_y};
            r_head <= i_in.robot_heading;
            r_num  <= num_now;
        end
        if (finish) begin
            r_dist    <= root;
            r_rel     <= ang - r_head;
            r_vis     <= (root < {1'b0, r_max_range});
            r_out_num <= r_num;
        end
    end

    lrb_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == T_LOAD),
        .i_dx    (r_dx),
        .i_dy    (r_dy),
        .o_done  (sq_done),
        .o_root  (root)
    );

    lrb_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == T_LOAD),
        .i_dx    (r_dx),
        .i_dy    (r_dy),
        .o_done  (cd_done),
        .o_z     (z)
    );

    assign i_in.ready            = (r_state == T_IDLE);
    assign o_out.valid           = r_out_valid;
    assign o_out.distance        = r_dist;
    assign o_out.relative_angle  = r_rel;
    assign o_out.visible         = r_vis;
    assign o_out.landmark_number = r_out_num;

endmodule

`default_nettype wire

// ===== rtl/core/lrb_isqrt.sv =====
// lrb_isqrt: floor(sqrt(dx^2 + dy^2)) with one shared 32x32 multiplier and a
// one-bit-per-cycle restoring square root. Depends on lrb_pkg.
`default_nettype none

module lrb_isqrt import lrb_pkg::*; (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire logic signed [DIFF_W-1:0] i_dx,
    input  wire logic signed [DIFF_W-1:0] i_dy,
    output logic                          o_done,
    output logic [DIST_W-1:0]             o_root
);

    localparam int PROD_W = 2 * POS_W;
    localparam int RAD_W  = 2 * DIST_W;     // radicand padded to even width
    localparam int REM_W  = DIST_W + 4;
    localparam int K_W    = $clog2(DIST_W);

    typedef enum logic [5:0] {
        Q_IDLE = 6'b000001,
        Q_MX   = 6'b000010,
        Q_MY   = 6'b000100,
        Q_SUM  = 6'b001000,
        Q_ROOT = 6'b010000,
        Q_DONE = 6'b100000
    } t_sq_state;

    t_sq_state          r_state, n_state;
    logic [POS_W-1:0]   r_ux, r_uy;
    logic [PROD_W-1:0]  r_prod;
    logic [RAD_W-1:0]   r_rad;
    logic [REM_W-1:0]   r_rem;
    logic [DIST_W-1:0]  r_root;
    logic [K_W-1:0]     r_k;

    logic [DIFF_W-1:0]  abs_dx, abs_dy;
    logic [POS_W-1:0]   mul_op;
    logic [PROD_W-1:0]  mul_res;
    logic [PROD_W:0]    sum;
    logic [REM_W-1:0]   rem_sh, trial;
    logic               ge;

    // |d| <= 2^32 - 1, so the low 32 bits carry it
    assign abs_dx  = i_dx[DIFF_W-1] ? DIFF_W'(-i_dx) : DIFF_W'(i_dx);
    assign abs_dy  = i_dy[DIFF_W-1] ? DIFF_W'(-i_dy) : DIFF_W'(i_dy);
    assign mul_op  = (r_state == Q_MX) ? r_ux : r_uy;
    assign mul_res = PROD_W'(mul_op) * PROD_W'(mul_op);
    assign sum     = {1'b0, r_rad[PROD_W-1:0]} + {1'b0, r_prod};

    assign rem_sh = {r_rem[REM_W-3:0], r_rad[RAD_W-1 -: 2]};
    assign trial  = {2'b00, r_root, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            Q_IDLE, Q_DONE: if (i_start) n_state = Q_MX;
            Q_MX:           n_state = Q_MY;
            Q_MY:           n_state = Q_SUM;
            Q_SUM:          n_state = Q_ROOT;
            Q_ROOT:         if (r_k == '0) n_state = Q_DONE;
            default:        n_state = Q_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= Q_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            Q_IDLE, Q_DONE: begin
                if (i_start) begin
                    r_ux <= abs_dx[POS_W-1:0];
                    r_uy <= abs_dy[POS_W-1:0];
                end
            end
            Q_MX: begin
                r_prod <= mul_res;
            end
            Q_MY: begin
                r_rad  <= RAD_W'(r_prod);
                r_prod <= mul_res;
            end
            Q_SUM: begin
                r_rad  <= RAD_W'(sum);
                r_rem  <= '0;
                r_root <= '0;
                r_k    <= K_W'(DIST_W - 1);
            end
            Q_ROOT: begin
                r_rem  <= ge ? (rem_sh - trial) : rem_sh;
                r_root <= {r_root[DIST_W-2:0], ge};
                r_rad  <= {r_rad[RAD_W-3:0], 2'b00};
                r_k    <= r_k - 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign o_done = (r_state == Q_DONE);
    assign o_root = r_root;

endmodule

`default_nettype wire

// ===== rtl/core/lrb_cordic.sv =====
// lrb_cordic: iterative vectoring CORDIC, atan2(dy, dx) in 2^32 units per turn,
// one micro-rotation per cycle. Depends on lrb_pkg.
`default_nettype none

module lrb_cordic import lrb_pkg::*; #(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire logic signed [DIFF_W-1:0] i_dx,
    input  wire logic signed [DIFF_W-1:0] i_dy,
    output logic                          o_done,
    output logic [Z_W-1:0]                o_z
);

    localparam int EXT_W = CORDIC_W - DIFF_W;
    localparam int LAST  = (CORDIC_STEPS > ATAN_N) ? ATAN_N - 1 : CORDIC_STEPS - 1;

    typedef enum logic [2:0] {
        C_IDLE = 3'b001,
        C_RUN  = 3'b010,
        C_DONE = 3'b100
    } t_cd_state;

    t_cd_state                   r_state, n_state;
    logic signed [CORDIC_W-1:0]  r_x, r_y;
    logic [Z_W-1:0]              r_z;
    logic [IDX_W-1:0]            r_i;

    logic signed [CORDIC_W-1:0]  ex, ey, xs, ys;
    logic                        zero_in, y_pos;

    assign ex      = {{EXT_W{i_dx[DIFF_W-1]}}, i_dx};
    assign ey      = {{EXT_W{i_dy[DIFF_W-1]}}, i_dy};
    assign zero_in = (i_dx == '0) && (i_dy == '0);
    assign xs      = r_x >>> r_i;
    assign ys      = r_y >>> r_i;
    assign y_pos   = !r_y[CORDIC_W-1] && (r_y != '0);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            C_IDLE, C_DONE: if (i_start) n_state = zero_in ? C_DONE : C_RUN;
            C_RUN:          if (r_i == IDX_W'(LAST)) n_state = C_DONE;
            default:        n_state = C_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            C_IDLE, C_DONE: begin
                if (i_start) begin
                    r_i <= '0;
                    // left half-plane: rotate by pi first
                    if (i_dx[DIFF_W-1]) begin
                        r_x <= -ex;
                        r_y <= -ey;
                        r_z <= Z_HALF_TURN;
                    end else begin
                        r_x <= ex;
                        r_y <= ey;
                        r_z <= '0;
                    end
                end
            end
            C_RUN: begin
                r_i <= r_i + 1'b1;
                if (y_pos) begin
                    r_x <= r_x + ys;
                    r_y <= r_y - xs;
                    r_z <= r_z + ATAN_TAB[r_i];
                end else begin
                    r_x <= r_x - ys;
                    r_y <= r_y + xs;
                    r_z <= r_z - ATAN_TAB[r_i];
                end
            end
            default: begin
            end
        endcase
    end

    assign o_done = (r_state == C_DONE);
    assign o_z    = r_z;

endmodule

`default_nettype wire

// ===== rtl/core/lrb_chk.sv =====
// lrb_chk: port-level checks for landmark_range_bearing, bound to the top.
// Depends on lrb_pkg and landmark_range_bearing.
`default_nettype none

module lrb_chk import lrb_pkg::*; (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_in_valid,
    input wire logic              i_in_ready,
    input wire logic              i_out_valid,
    input wire logic              i_out_ready,
    input wire logic [DIST_W-1:0] i_out_distance
);

    // a result beat waiting on the receiver stays valid and keeps its distance
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_distance))
        else $error("result beat changed while stalled");

    // one item in flight: an accepted beat closes the input
    a_one_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input open right after an accepted beat");

    // a new result only appears out of the busy phase
    a_res_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(!i_in_ready))
        else $error("result raised while the block was idle");

    a_rst_clr: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid survived reset");

endmodule

bind landmark_range_bearing lrb_chk u_lrb_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_distance (o_out.distance)
);

`default_nettype wire

// ===== dv/tb_landmark_range_bearing.sv =====
// tb_landmark_range_bearing: self-checking bench for the landmark range/bearing block.
// Predicts distance, bearing, visibility and landmark number per beat and scores
// the result channel. Depends on lrb_pkg, lrb_in_if, lrb_out_if, landmark_range_bearing.

module tb_landmark_range_bearing;
    import lrb_pkg::*;

    localparam int BEARING_STEPS = 16;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 60;
    localparam int MAX_REPORTS   = 10;
    localparam int METRE         = 65536;

    // atan(2^-i), 2^32 units per turn
    localparam logic [31:0] ATAN_STEP [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    typedef struct {
        logic                    start_of_frame;
        logic signed [POS_W-1:0] robot_x;
        logic signed [POS_W-1:0] robot_y;
        logic signed [ANG_W-1:0] robot_heading;
        logic signed [POS_W-1:0] landmark_x;
        logic signed [POS_W-1:0] landmark_y;
    } t_landmark;

    typedef struct {
        logic [DIST_W-1:0]       distance;
        logic signed [ANG_W-1:0] relative_angle;
        logic                    visible;
        logic [NUM_W-1:0]        landmark_number;
    } t_observation;

    typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_CHOKED} t_rx_mode;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_wr_en;
    logic [POS_W-1:0] i_cfg_wr_data;

    lrb_in_if  in_if ();
    lrb_out_if out_if ();

    landmark_range_bearing #(
        .CORDIC_STEPS (BEARING_STEPS)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in          (in_if),
        .o_out         (out_if)
    );

    t_landmark        pending_landmarks [$];
    t_observation     expected_obs [$];
    t_landmark        beat_item;
    logic [POS_W-1:0] max_range_now;
    logic [NUM_W-1:0] frame_count;
    int               mismatch_count;
    int               cycle_count;
    int               burst_left;
    int               gap_left;
    t_rx_mode         rx_mode;
    int               mode_left;
    int               choke_left;
    logic             next_ready;

    always #5 i_clk = ~i_clk;

    // Range by bitwise integer sqrt, bearing by vectoring CORDIC, then the frame counter.
    function automatic t_observation predict_observation(t_landmark lm);
        longint        dx, dy, cx, cy, xs, ys;
        logic [65:0]   ux, uy, sumsq, trial_sq;
        logic [32:0]   root, trial;
        logic [31:0]   z, z_round;
        logic [15:0]   ang;
        int            steps;
        t_observation  obs;
        dx = longint'(lm.landmark_x) - longint'(lm.robot_x);
        dy = longint'(lm.landmark_y) - longint'(lm.robot_y);
        ux = 66'(dx < 0 ? -dx : dx);
        uy = 66'(dy < 0 ? -dy : dy);
        sumsq = ux * ux + uy * uy;
        root = '0;
        for (int b = 32; b >= 0; b--) begin
            trial = root | (33'd1 << b);
            trial_sq = 66'(trial) * 66'(trial);
            if (trial_sq <= sumsq)
                root = trial;
        end

        z = '0;
        if (dx != 0 || dy != 0) begin
            steps = (BEARING_STEPS > 32) ? 32 : BEARING_STEPS;
            cx = dx;
            cy = dy;
            if (cx < 0) begin
                cx = -cx;
                cy = -cy;
                z = 32'h8000_0000;
            end
            for (int i = 0; i < steps; i++) begin
                xs = cx >>> i;
                ys = cy >>> i;
                if (cy > 0) begin
                    cx = cx + ys;
                    cy = cy - xs;
                    z = z + ATAN_STEP[i];
                end else begin
                    cx = cx - ys;
                    cy = cy + xs;
                    z = z - ATAN_STEP[i];
                end
            end
        end
        z_round = z + 32'h0000_8000;
        ang = z_round[31:16];

        if (lm.start_of_frame)
            frame_count = '0;
        obs.distance        = root;
        obs.relative_angle  = ang - lm.robot_heading;
        obs.visible         = (root < {1'b0, max_range_now});
        obs.landmark_number = frame_count;
        if (frame_count != 16'hFFFF)
            frame_count = frame_count + 1'b1;
        return obs;
    endfunction

    task automatic note_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    task automatic check_observation();
        t_observation want;
        if (expected_obs.size() == 0) begin
            note_mismatch($sformatf("unexpected result dist=%0d ang=%0d vis=%0b num=%0d",
                out_if.distance, out_if.relative_angle, out_if.visible,
                out_if.landmark_number));
        end else begin
            want = expected_obs.pop_front();
            if (out_if.distance !== want.distance)
                note_mismatch($sformatf("distance exp=%0d act=%0d",
                    want.distance, out_if.distance));
            if (out_if.relative_angle !== want.relative_angle)
                note_mismatch($sformatf("relative_angle exp=%0d act=%0d",
                    want.relative_angle, out_if.relative_angle));
            if (out_if.visible !== want.visible)
                note_mismatch($sformatf("visible exp=%0b act=%0b (dist %0d)",
                    want.visible, out_if.visible, want.distance));
            if (out_if.landmark_number !== want.landmark_number)
                note_mismatch($sformatf("landmark_number exp=%0d act=%0d",
                    want.landmark_number, out_if.landmark_number));
        end
    endtask

    // Sender: bursts of beats separated by random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end else begin
            if (in_if.valid && in_if.ready)
                expected_obs.insert(expected_obs.size(), predict_observation(beat_item));
            if (in_if.valid && !in_if.ready) begin
                // beat still waiting, hold it
            end else if (gap_left > 0) begin
                gap_left--;
                in_if.valid <= 1'b0;
            end else if (pending_landmarks.size() > 0) begin
                beat_item = pending_landmarks.pop_front();
                in_if.valid          <= 1'b1;
                in_if.start_of_frame <= beat_item.start_of_frame;
                in_if.robot_x        <= beat_item.robot_x;
                in_if.robot_y        <= beat_item.robot_y;
                in_if.robot_heading  <= beat_item.robot_heading;
                in_if.landmark_x     <= beat_item.landmark_x;
                in_if.landmark_y     <= beat_item.landmark_y;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 15);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
                end
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // Receiver: scores each result beat; ready follows a mode that changes now and then.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            rx_mode = RX_OPEN;
            mode_left = 200;
            choke_left = 0;
        end else begin
            if (out_if.valid && out_if.ready)
                check_observation();
            if (mode_left == 0) begin
                rx_mode = t_rx_mode'($urandom_range(0, 2));
                mode_left = $urandom_range(100, 600);
            end else begin
                mode_left--;
            end
            case (rx_mode)
                RX_OPEN: next_ready = 1'b1;
                RX_RANDOM: next_ready = 1'($urandom_range(0, 1));
                default: begin
                    if (choke_left > 0) begin
                        choke_left--;
                        next_ready = 1'b0;
                    end else begin
                        next_ready = 1'b1;
                        if ($urandom_range(0, 2) == 0)
                            choke_left = $urandom_range(10, 60);
                    end
                end
            endcase
            out_if.ready <= next_ready;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic queue_landmark(logic sof, logic [31:0] rx, logic [31:0] ry,
                                  logic [15:0] hd, logic [31:0] lx, logic [31:0] ly);
        t_landmark lm;
        lm.start_of_frame = sof;
        lm.robot_x        = rx;
        lm.robot_y        = ry;
        lm.robot_heading  = hd;
        lm.landmark_x     = lx;
        lm.landmark_y     = ly;
        pending_landmarks.insert(pending_landmarks.size(), lm);
    endtask

    function automatic logic [31:0] near_coord(int span_m);
        return 32'($urandom_range(0, 2 * span_m * METRE) - span_m * METRE);
    endfunction

    // Mostly frames: start_of_frame on the first beat, one pose, nearby landmarks.
    task automatic queue_random_frames(int count);
        logic [31:0] rx, ry, lx, ly;
        logic [15:0] hd;
        int          frame_len;
        logic        wild_pose;
        while (count > 0) begin
            if ($urandom_range(0, 9) == 0) begin
                // stray beat, arbitrary content
                queue_landmark(1'($urandom_range(0, 1)), $urandom, $urandom,
                               16'($urandom), $urandom, $urandom);
                count--;
            end else begin
                wild_pose = ($urandom_range(0, 4) == 0);
                rx = wild_pose ? $urandom : near_coord(50);
                ry = wild_pose ? $urandom : near_coord(50);
                hd = 16'($urandom);
                frame_len = $urandom_range(1, 12);
                for (int k = 0; k < frame_len && count > 0; k++) begin
                    if ($urandom_range(0, 6) == 0) begin
                        lx = $urandom;
                        ly = $urandom;
                    end else begin
                        lx = rx + near_coord(20);
                        ly = ry + near_coord(20);
                    end
                    queue_landmark(k == 0, rx, ry, hd, lx, ly);
                    count--;
                end
            end
        end
    endtask

    task automatic wait_results_drained();
        @(negedge i_clk);
        while (pending_landmarks.size() != 0 || in_if.valid || expected_obs.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic write_max_range(logic [31:0] value);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        max_range_now = value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    initial begin
        i_clk                = 1'b0;
        i_rst_n              = 1'b0;
        i_cfg_wr_en          = 1'b0;
        i_cfg_wr_data        = '0;
        in_if.valid          = 1'b0;
        in_if.start_of_frame = 1'b0;
        in_if.robot_x        = '0;
        in_if.robot_y        = '0;
        in_if.robot_heading  = '0;
        in_if.landmark_x     = '0;
        in_if.landmark_y     = '0;
        out_if.ready         = 1'b0;
        mismatch_count       = 0;
        cycle_count          = 0;
        max_range_now        = MAX_RANGE_RST;
        frame_count          = '0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed beats at the reset range limit
        queue_landmark(1, 0, 0, 0, 0, 0);                           // coincident points
        queue_landmark(0, 32'h1234_5678, 32'h9ABC_DEF0, 16'h4000,
                       32'h1234_5678, 32'h9ABC_DEF0);               // coincident, heading
        queue_landmark(0, 0, 0, 0, METRE, 0);                       // straight ahead
        queue_landmark(0, 0, 0, 0, -METRE, 0);                      // exactly pi
        queue_landmark(0, 0, 0, 16'h8000, -METRE, 0);               // pi minus pi
        queue_landmark(0, 0, 0, 16'h7FFF, -METRE, 1);               // just below pi
        queue_landmark(0, 0, 0, 16'h7FFF, -METRE, -1);              // just past pi
        queue_landmark(0, 0, 0, 0, 0, METRE);                       // +y
        queue_landmark(0, 0, 0, 16'h8000, 0, -METRE);               // -y
        queue_landmark(0, 0, 0, 0, 10 * METRE, 0);                  // range at the limit
        queue_landmark(0, 0, 0, 0, 10 * METRE - 1, 0);              // just inside
        queue_landmark(1, 32'h8000_0000, 32'h8000_0000, 16'h8000,
                       32'h7FFF_FFFF, 32'h7FFF_FFFF);               // longest range
        queue_landmark(0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h7FFF,
                       32'h8000_0000, 32'h8000_0000);
        queue_landmark(0, 32'h7FFF_FFFF, 0, 16'hFFFF, 32'h8000_0000, 0);
        queue_landmark(0, 0, 32'h8000_0000, 16'h0001, 0, 32'h7FFF_FFFF);
        queue_landmark(0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0);
        queue_landmark(0, 0, 0, 0, 3 * METRE, -4 * METRE);
        queue_landmark(1, 5 * METRE, 5 * METRE, 16'hC000, 2 * METRE, 9 * METRE);
        queue_landmark(0, 5 * METRE, 5 * METRE, 16'hC000, 1, -1);
        queue_landmark(0, 5 * METRE, 5 * METRE, 16'hC000, $urandom, $urandom);
        wait_results_drained();

        queue_random_frames(150);
        wait_results_drained();

        write_max_range(32'd0);
        queue_random_frames(80);
        wait_results_drained();

        write_max_range(32'hFFFF_FFFF);
        queue_random_frames(80);
        wait_results_drained();

        write_max_range($urandom_range(1, 40 * METRE));
        queue_random_frames(150);
        wait_results_drained();

        write_max_range(32'd1);
        queue_random_frames(40);
        wait_results_drained();

        write_max_range(20 * METRE);
        queue_random_frames(100);
        wait_results_drained();

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_obs.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
